// ===== rtl/tssa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssa_pkg
// Shared types and constants of the timed servo slew axis.
// ----------------------------------------------------------------------------
package tssa_pkg;

  // Request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_TIMED = 3'd1;
  localparam logic [2:0] REQ_SLOW  = 3'd2;
  localparam logic [2:0] REQ_STEP  = 3'd3;
  localparam logic [2:0] REQ_SET   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_DEG = 2'd0;
  localparam logic [1:0] CFG_MAX_DEG = 2'd1;
  localparam logic [1:0] CFG_REV_DIR = 2'd2;

  localparam logic signed [7:0] MIN_DEG_RST = -8'sd70;
  localparam logic signed [7:0] MAX_DEG_RST = 8'sd70;

  // Serial arithmetic sizes
  localparam int MUL_W   = 8;   // operand width of the shift-add multiplier
  localparam int DIV_N   = 16;  // dividend and quotient width
  localparam int DIV_D   = 9;   // divisor width
  localparam int MUL_CW  = $clog2(MUL_W);
  localparam int DIV_CW  = $clog2(DIV_N);

  localparam logic [DIV_D-1:0] MAP_SCALE   = 9'd200;
  localparam logic [16:0]      ELAPSED_MAX = 17'h1FFFF;

  localparam logic signed [7:0] SET_LO = -8'sd90;
  localparam logic signed [7:0] SET_HI = 8'sd90;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== rtl/tssa_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssa_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tssa_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tssa_pkg::MUL_W-1:0]     a_i,
  input  logic [tssa_pkg::MUL_W-1:0]     b_i,
  output logic [2*tssa_pkg::MUL_W-1:0]   prod_o,
  output tssa_pkg::unit_sts_t            sts_o
);
  import tssa_pkg::*;

  logic              busy_q, done_q;
  logic [MUL_CW-1:0] cnt_q;
  logic [MUL_W-1:0]  b_q;
  logic [2*MUL_W-1:0] p_q;
  logic [MUL_W:0]    sum;

  // add the multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, p_q[2*MUL_W-1:MUL_W]} + (p_q[0] ? {1'b0, b_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CW'(MUL_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      b_q <= b_i;
      p_q <= {{MUL_W{1'b0}}, a_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[MUL_W-1:1]};
    end
  end

  assign prod_o     = p_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/tssa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tssa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tssa_pkg::DIV_N-1:0]   dividend_i,
  input  logic [tssa_pkg::DIV_D-1:0]   divisor_i,
  output logic [tssa_pkg::DIV_N-1:0]   quot_o,
  output tssa_pkg::unit_sts_t          sts_o
);
  import tssa_pkg::*;

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_D-1:0]  dsr_q;
  logic [DIV_D-1:0]  rem_q;
  logic [DIV_N-1:0]  quo_q;
  logic [DIV_D:0]    rem_sh;
  logic [DIV_D:0]    diff;
  logic              fits;

  // shift in the next dividend bit, subtract when it fits
  assign rem_sh = {rem_q, quo_q[DIV_N-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_N - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_D-1:0] : rem_sh[DIV_D-1:0];
      quo_q <= {quo_q[DIV_N-2:0], fits};
    end
  end

  assign quot_o     = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/timed_servo_slew_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_servo_slew_axis
// One servo axis: millisecond-paced one-degree slewing toward a mapped target.
// ----------------------------------------------------------------------------
// Path from accept to result valid: tick, step, set, unused codes and refused
// starts pass through APPLY to OUT; a slow start runs the serial multiply and
// one serial divide, and a timed start adds a second divide for the interval.
// One item at a time: the next item is taken the cycle after the result
// enters the output register.
// Reset (async, active low) clears the axis state and loads limits -70 and 70.
module timed_servo_slew_axis (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        req_type_i,
  input  logic signed [7:0] ratio_i,
  input  logic [15:0]       duration_ms_i,
  input  logic signed [7:0] set_degrees_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        servo_angle_o,
  output logic signed [7:0] position_o,
  output logic              moving_o,
  output logic              accepted_o,
  output logic              arrived_o
);
  import tssa_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPLY  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIVMAP = 3'd3;
  localparam logic [2:0] ST_DIVGO  = 3'd4;
  localparam logic [2:0] ST_DIVINT = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] st_q, st_d;

  // configuration
  logic signed [7:0] min_q, max_q;
  logic              rev_q;

  // axis state
  logic signed [7:0] cur_q, cur_d, tgt_q, tgt_d;
  logic              busy_q, busy_d;
  logic [16:0]       ivl_q, ivl_d, el_q, el_d;

  // item in progress
  logic [2:0]        req_q;
  logic [15:0]       dur_q;
  logic signed [7:0] setd_q;
  logic              neg_q, neg_d;
  logic              acc_q, acc_d, arr_q, arr_d;

  // output register
  logic              ovalid_q;
  logic [7:0]        ang_q;
  logic signed [7:0] pos_q;
  logic              mov_q, oacc_q, oarr_q;

  logic              in_acc, is_start, out_load;
  logic              mul_start, div_start;
  logic [2*MUL_W-1:0] prod;
  logic [DIV_N-1:0]  quot;
  unit_sts_t         mul_sts, div_sts;
  logic [DIV_N-1:0]  div_dvd;
  logic [DIV_D-1:0]  div_dsr;

  logic signed [8:0] r9, r9_neg, span9, span9_neg;
  logic [7:0]        r_abs, span_abs;

  logic [9:0]        qs10;
  logic signed [10:0] conv11, min11, max11;
  logic signed [7:0] map_tgt;

  logic signed [8:0] dist9, dist9_neg;
  logic [7:0]        dist_abs;

  logic [16:0]       el_inc;
  logic signed [7:0] stp_cur;
  logic              stp_busy, stp_arr;
  logic signed [7:0] set_clamped;

  logic signed [8:0] sum9, half9;
  logic signed [9:0] center10, pos10, ang10;
  logic [7:0]        ang_sat;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_start   = (req_type_i == REQ_TIMED) || (req_type_i == REQ_SLOW);
  assign out_load   = (st_q == ST_OUT) && (!ovalid_q || !out_stall_i);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_DEG_RST;
      max_q <= MAX_DEG_RST;
      rev_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DEG: min_q <= cfg_wdata_i;
        CFG_MAX_DEG: max_q <= cfg_wdata_i;
        CFG_REV_DIR: rev_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ratio mapping operands, taken as magnitudes with a separate sign
  assign r9        = $signed({ratio_i[7], ratio_i}) + 9'sd100;
  assign r9_neg    = -r9;
  assign r_abs     = r9[8] ? r9_neg[7:0] : r9[7:0];
  assign span9     = $signed({max_q[7], max_q}) - $signed({min_q[7], min_q});
  assign span9_neg = -span9;
  assign span_abs  = span9[8] ? span9_neg[7:0] : span9[7:0];

  assign mul_start = in_acc & is_start & ~busy_q;

  tssa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (r_abs),
    .b_i     (span_abs),
    .prod_o  (prod),
    .sts_o   (mul_sts)
  );

  // distance to the new target for the interval divide
  assign dist9     = $signed({tgt_q[7], tgt_q}) - $signed({cur_q[7], cur_q});
  assign dist9_neg = -dist9;
  assign dist_abs  = dist9[8] ? dist9_neg[7:0] : dist9[7:0];

  assign div_start = ((st_q == ST_MUL) && mul_sts.done) || (st_q == ST_DIVGO);
  assign div_dvd   = (st_q == ST_MUL) ? prod : dur_q;
  assign div_dsr   = (st_q == ST_MUL) ? MAP_SCALE : ({1'b0, dist_abs} + 9'd1);

  tssa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quot_o     (quot),
    .sts_o      (div_sts)
  );

  // apply the sign, add the low limit, constrain to the limits
  assign qs10   = neg_q ? (10'd0 - {1'b0, quot[8:0]}) : {1'b0, quot[8:0]};
  assign min11  = {{3{min_q[7]}}, min_q};
  assign max11  = {{3{max_q[7]}}, max_q};
  assign conv11 = $signed({qs10[9], qs10}) + min11;
  always_comb begin
    if (conv11 < min11) begin
      map_tgt = min_q;
    end else if (conv11 > max11) begin
      map_tgt = max_q;
    end else begin
      map_tgt = conv11[7:0];
    end
  end

  // one degree toward target
  always_comb begin
    stp_cur  = cur_q;
    stp_busy = busy_q;
    stp_arr  = 1'b0;
    if (busy_q) begin
      if (tgt_q < cur_q) begin
        stp_cur = cur_q - 8'sd1;
      end else if (tgt_q > cur_q) begin
        stp_cur = cur_q + 8'sd1;
      end else begin
        stp_busy = 1'b0;
        stp_arr  = 1'b1;
      end
    end
  end

  assign el_inc = (el_q == ELAPSED_MAX) ? el_q : el_q + 17'd1;

  always_comb begin
    if (setd_q < SET_LO) begin
      set_clamped = SET_LO;
    end else if (setd_q > SET_HI) begin
      set_clamped = SET_HI;
    end else begin
      set_clamped = setd_q;
    end
  end

  // sequencer
  always_comb begin
    st_d   = st_q;
    cur_d  = cur_q;
    tgt_d  = tgt_q;
    busy_d = busy_q;
    ivl_d  = ivl_q;
    el_d   = el_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    arr_d  = arr_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          acc_d = 1'b0;
          arr_d = 1'b0;
          neg_d = r9[8] ^ span9[8];
          st_d  = mul_start ? ST_MUL : ST_APPLY;
        end
      end
      ST_APPLY: begin
        case (req_q)
          REQ_TICK: begin
            if (el_inc > ivl_q) begin
              el_d   = '0;
              cur_d  = stp_cur;
              busy_d = stp_busy;
              arr_d  = stp_arr;
            end else begin
              el_d = el_inc;
            end
          end
          REQ_STEP: begin
            cur_d  = stp_cur;
            busy_d = stp_busy;
            arr_d  = stp_arr;
          end
          REQ_SET: cur_d = set_clamped;
          default: ;
        endcase
        st_d = ST_OUT;
      end
      ST_MUL: begin
        if (mul_sts.done) begin
          st_d = ST_DIVMAP;
        end
      end
      ST_DIVMAP: begin
        if (div_sts.done) begin
          tgt_d  = map_tgt;
          busy_d = 1'b1;
          acc_d  = 1'b1;
          st_d   = (req_q == REQ_TIMED) ? ST_DIVGO : ST_OUT;
        end
      end
      ST_DIVGO: st_d = ST_DIVINT;
      ST_DIVINT: begin
        if (div_sts.done) begin
          ivl_d = {1'b0, quot} + 17'd1;
          st_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cur_q  <= '0;
      tgt_q  <= '0;
      busy_q <= 1'b0;
      ivl_q  <= '0;
      el_q   <= '0;
      neg_q  <= 1'b0;
      acc_q  <= 1'b0;
      arr_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      cur_q  <= cur_d;
      tgt_q  <= tgt_d;
      busy_q <= busy_d;
      ivl_q  <= ivl_d;
      el_q   <= el_d;
      neg_q  <= neg_d;
      acc_q  <= acc_d;
      arr_q  <= arr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_type_i;
      dur_q  <= duration_ms_i;
      setd_q <= set_degrees_i;
    end
  end

  // servo angle: center plus signed position, saturated
  assign sum9     = $signed({min_q[7], min_q}) + $signed({max_q[7], max_q});
  assign half9    = (sum9 + $signed({8'd0, sum9[8]})) >>> 1;
  assign center10 = 10'sd90 + $signed({half9[8], half9});
  assign pos10    = rev_q ? -$signed({{2{cur_q[7]}}, cur_q})
                          : $signed({{2{cur_q[7]}}, cur_q});
  assign ang10    = center10 + pos10;
  always_comb begin
    if (ang10 < 10'sd0) begin
      ang_sat = 8'd0;
    end else if (ang10 > 10'sd180) begin
      ang_sat = 8'd180;
    end else begin
      ang_sat = ang10[7:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ang_q  <= ang_sat;
      pos_q  <= cur_q;
      mov_q  <= busy_q;
      oacc_q <= acc_q;
      oarr_q <= arr_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign servo_angle_o = ang_q;
  assign position_o    = pos_q;
  assign moving_o      = mov_q;
  assign accepted_o    = oacc_q;
  assign arrived_o     = oarr_q;

endmodule

// ===== rtl/tssa_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssa_chk
// Port-level checks of the timed servo slew axis, bound to the top level.
// ----------------------------------------------------------------------------
module tssa_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [7:0]        servo_angle_o,
  input logic signed [7:0] position_o,
  input logic              moving_o,
  input logic              accepted_o,
  input logic              arrived_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(servo_angle_o)
      && $stable(position_o) && $stable(moving_o))
    else $error("stalled result changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in work");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> servo_angle_o <= 8'd180)
    else $error("servo angle above 180");

  // a taken start leaves the axis moving and cannot also end a move
  a_accept_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> moving_o && !arrived_o)
    else $error("accepted start without a move in progress");

  a_arrive_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arrived_o |-> !moving_o)
    else $error("arrival reported while still moving");

endmodule

bind timed_servo_slew_axis tssa_chk u_tssa_chk (.*);

// ===== tb/timed_servo_slew_axis_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_servo_slew_axis_tb
// Self-checking bench for one servo slew axis. An in-bench tracker follows
// angle, target, move flag, step interval and millisecond count. It predicts
// the status item for every accepted request and compares each delivered
// status field by field. The run covers directed corner requests, then
// well-formed moves with random content, mixed with noise. Several limit and
// direction settings are used, the extremes and crossed limits among them.
// Both handshakes idle at random, except in one calm phase.
// ----------------------------------------------------------------------------
module timed_servo_slew_axis_tb;
  import tssa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 95;
  localparam int N_PHASES    = 10;

  typedef struct packed {
    logic [7:0]        angle;
    logic signed [7:0] pos;
    logic              moving;
    logic              accepted;
    logic              arrived;
  } axis_status_t;

  class axis_tracker;
    int           min_deg;
    int           max_deg;
    bit           rev;
    int           cur_pos;
    int           target_pos;
    bit           busy;
    logic [16:0]  interval;
    logic [16:0]  elapsed;
    axis_status_t pending_status[$];
    int           errors;

    function new();
      min_deg    = MIN_DEG_RST;
      max_deg    = MAX_DEG_RST;
      rev        = 1'b0;
      cur_pos    = 0;
      target_pos = 0;
      busy       = 1'b0;
      interval   = '0;
      elapsed    = '0;
      errors     = 0;
    endfunction

    function int clip(int x, int lo, int hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function void configure(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_MIN_DEG: min_deg = $signed(val);
        CFG_MAX_DEG: max_deg = $signed(val);
        CFG_REV_DIR: rev = val[0];
        default: ;
      endcase
    endfunction

    // Linear map of -100..100 onto min_deg..max_deg, then constrain.
    function int map_target(int ratio);
      return clip((ratio + 100) * (max_deg - min_deg) / 200 + min_deg, min_deg, max_deg);
    endfunction

    function bit step_toward();
      if (!busy) return 1'b0;
      if (target_pos < cur_pos) cur_pos--;
      else if (target_pos > cur_pos) cur_pos++;
      else begin
        busy = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit begin_move(int ratio, bit timed, int dur);
      int gap;
      if (busy) return 1'b0;
      busy       = 1'b1;
      target_pos = map_target(ratio);
      if (timed) begin
        gap = target_pos - cur_pos;
        if (gap < 0) gap = -gap;
        interval = 17'(dur / (gap + 1) + 1);
      end
      return 1'b1;
    endfunction

    function void apply_request(logic [2:0] rq, logic signed [7:0] ratio, logic [15:0] dur,
                                logic signed [7:0] setd);
      axis_status_t s;
      int           ang;
      s = '0;
      case (rq)
        REQ_TICK: begin
          if (elapsed < ELAPSED_MAX) elapsed++;
          if (elapsed > interval) begin
            elapsed   = '0;
            s.arrived = step_toward();
          end
        end
        REQ_TIMED: s.accepted = begin_move(ratio, 1'b1, int'(dur));
        REQ_SLOW:  s.accepted = begin_move(ratio, 1'b0, 0);
        REQ_STEP:  s.arrived = step_toward();
        REQ_SET:   cur_pos = clip(setd, SET_LO, SET_HI);
        default: ;
      endcase
      ang = clip(90 + (max_deg + min_deg) / 2 + (rev ? -cur_pos : cur_pos), 0, 180);
      s.angle  = 8'(ang);
      s.pos    = 8'(cur_pos);
      s.moving = busy;
      pending_status.push_back(s);
    endfunction

    function void check_status(logic [7:0] angle, logic signed [7:0] pos, logic moving,
                               logic accepted, logic arrived);
      axis_status_t e;
      if (pending_status.size() == 0) begin
        $error("status item with no request outstanding: angle %0d position %0d",
               angle, pos);
        errors++;
        return;
      end
      e = pending_status.pop_front();
      if (angle !== e.angle) begin
        $error("servo_angle: expected %0d, got %0d", e.angle, angle);
        errors++;
      end
      if (pos !== e.pos) begin
        $error("position: expected %0d, got %0d", $signed(e.pos), pos);
        errors++;
      end
      if (moving !== e.moving) begin
        $error("moving: expected %0d, got %0d", e.moving, moving);
        errors++;
      end
      if (accepted !== e.accepted) begin
        $error("accepted: expected %0d, got %0d", e.accepted, accepted);
        errors++;
      end
      if (arrived !== e.arrived) begin
        $error("arrived: expected %0d, got %0d", e.arrived, arrived);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [7:0]        cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        req_type_i;
  logic signed [7:0] ratio_i;
  logic [15:0]       duration_ms_i;
  logic signed [7:0] set_degrees_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [7:0]        servo_angle_o;
  logic signed [7:0] position_o;
  logic              moving_o;
  logic              accepted_o;
  logic              arrived_o;

  axis_tracker sb;
  bit          calm;
  int          n_sent;
  int          n_cycles;

  timed_servo_slew_axis u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .ratio_i       (ratio_i),
    .duration_ms_i (duration_ms_i),
    .set_degrees_i (set_degrees_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .servo_angle_o (servo_angle_o),
    .position_o    (position_o),
    .moving_o      (moving_o),
    .accepted_o    (accepted_o),
    .arrived_o     (arrived_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 33);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_status(servo_angle_o, position_o, moving_o, accepted_o, arrived_o);
  end

  function automatic int rand_ratio();
    return int'($urandom_range(200)) - 100;
  endfunction

  function automatic int rand_dur();
    if ($urandom_range(7) == 0) return int'($urandom_range(65535));
    return int'($urandom_range(63));
  endfunction

  // Mostly legal angles; now and then any 8-bit value to hit the clamp.
  function automatic int rand_set();
    if ($urandom_range(15) == 0) return int'($urandom_range(255)) - 128;
    return int'($urandom_range(180)) - 90;
  endfunction

  function automatic logic [2:0] rand_unused();
    return 3'(5 + $urandom_range(2));
  endfunction

  // Enter and leave at a falling edge; valid stays up into the next call.
  task automatic issue_request(input logic [2:0] rq, input int ratio, input int dur,
                               input int setd);
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rq;
    ratio_i       <= 8'(ratio);
    duration_ms_i <= 16'(dur);
    set_degrees_i <= 8'(setd);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.apply_request(req_type_i, ratio_i, duration_ms_i, set_degrees_i);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every status item has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.configure(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Start a move, usually from close to its target, then pace it to the end.
  task automatic run_move();
    int ratio;
    int tgt;
    int n;
    int pick;
    ratio = rand_ratio();
    tgt   = sb.map_target(ratio);
    if (!sb.busy && $urandom_range(9) < 7)
      issue_request(REQ_SET, rand_ratio(), rand_dur(),
                    sb.clip(tgt + int'($urandom_range(8)) - 4, -90, 90));
    issue_request(($urandom_range(9) < 6) ? REQ_TIMED : REQ_SLOW, ratio, rand_dur(),
                  rand_set());
    n = 0;
    while (sb.busy && n < 60) begin
      pick = $urandom_range(99);
      if (pick < 70)
        issue_request(REQ_TICK, rand_ratio(), rand_dur(), rand_set());
      else if (pick < 88)
        issue_request(REQ_STEP, rand_ratio(), rand_dur(), rand_set());
      else if (pick < 93)
        issue_request(REQ_SET, rand_ratio(), rand_dur(),
                      sb.clip(sb.target_pos + int'($urandom_range(6)) - 3, -90, 90));
      else if (pick < 97)
        issue_request(($urandom_range(1) == 0) ? REQ_TIMED : REQ_SLOW, rand_ratio(),
                      rand_dur(), rand_set());
      else
        issue_request(rand_unused(), rand_ratio(), rand_dur(), rand_set());
      n++;
    end
  endtask

  task automatic run_noise();
    int n;
    n = 3 + $urandom_range(10);
    repeat (n) begin
      issue_request(($urandom_range(19) == 0) ? rand_unused() : 3'($urandom_range(4)),
                    rand_ratio(), rand_dur(), rand_set());
    end
  endtask

  initial begin
    int ph;
    int lo;
    int hi;
    int rv;
    int phase_start;
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MIN_DEG;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_TICK;
    ratio_i       = '0;
    duration_ms_i = '0;
    set_degrees_i = '0;
    out_stall_i   = 1'b0;
    calm          = 1'b0;
    n_sent        = 0;
    n_cycles      = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners at the reset limits.
    issue_request(REQ_TICK, 0, 0, 0);
    issue_request(REQ_TIMED, 100, 65535, 0);
    issue_request(REQ_SLOW, -100, 0, 0);      // refused: still moving
    issue_request(REQ_TIMED, 0, 0, 0);        // refused as well
    issue_request(REQ_STEP, 0, 0, 0);
    issue_request(REQ_SET, 0, 0, 69);
    issue_request(REQ_STEP, 0, 0, 0);
    issue_request(REQ_STEP, 0, 0, 0);         // at target: ends the move
    issue_request(REQ_STEP, 0, 0, 0);         // idle: no effect
    issue_request(REQ_SLOW, -100, 0, 0);      // keeps the old interval
    issue_request(REQ_SET, 0, 0, -70);
    issue_request(REQ_TICK, 0, 0, 0);
    issue_request(REQ_STEP, 0, 0, 0);
    issue_request(REQ_SET, 0, 0, 127);
    issue_request(REQ_SET, 0, 0, -128);
    issue_request(REQ_SET, 0, 0, 90);
    issue_request(REQ_SET, 0, 0, -90);
    issue_request(3'd5, 100, 65535, 90);
    issue_request(3'd6, -100, 65535, -90);
    issue_request(3'd7, -1, 65535, -1);
    issue_request(REQ_TIMED, -100, 0, 0);
    issue_request(REQ_TICK, 0, 0, 0);
    issue_request(REQ_TICK, 0, 0, 0);
    issue_request(REQ_SET, 0, 0, -70);
    issue_request(REQ_STEP, 0, 0, 0);

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin lo = -90; hi =  90; rv = 0; end
        1: begin lo = -90; hi =  90; rv = 1; end
        2: begin lo =  90; hi = -90; rv = 0; end
        3: begin lo =   0; hi =   0; rv = 1; end
        4: begin lo = -90; hi = -90; rv = 1; end
        5: begin lo =  90; hi =  90; rv = 0; end
        6: begin lo = -70; hi =  70; rv = 1; end
        7: begin lo = -30; hi =  80; rv = 0; end
        default: begin
          lo = int'($urandom_range(180)) - 90;
          hi = int'($urandom_range(180)) - 90;
          rv = $urandom_range(1);
        end
      endcase
      write_reg(CFG_MIN_DEG, 8'(lo));
      write_reg(CFG_MAX_DEG, 8'(hi));
      write_reg(CFG_REV_DIR, 8'(rv));
      calm        = (ph == 3);
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) run_noise();
        else run_move();
      end
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tssa_pkg.sv
rtl/tssa_mul.sv
rtl/tssa_div.sv
rtl/timed_servo_slew_axis.sv
rtl/tssa_chk.sv
tb/timed_servo_slew_axis_tb.sv
